// ===== sv/assert_macros.svh =====
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  `ASSERT_IMPL(label, clk, rst_n, !(expr))

`endif

// ===== sv/co2seq_pkg.sv =====
// shared types, codes and constants of the co2 sensor command sequencer
package co2seq_pkg;

  // request codes
  localparam logic [3:0] FN_BEGIN    = 4'd0;
  localparam logic [3:0] FN_START    = 4'd1;
  localparam logic [3:0] FN_START_LP = 4'd2;
  localparam logic [3:0] FN_STOP     = 4'd3;
  localparam logic [3:0] FN_SINGLE   = 4'd4;
  localparam logic [3:0] FN_READY    = 4'd5;
  localparam logic [3:0] FN_READ     = 4'd6;
  localparam logic [3:0] FN_PRESSURE = 4'd7;
  localparam logic [3:0] FN_OFFSET   = 4'd8;
  localparam logic [3:0] FN_DOWN     = 4'd9;
  localparam logic [3:0] FN_WAKE     = 4'd10;
  localparam logic [3:0] FN_SERIAL   = 4'd11;

  // issued command codes
  localparam logic [3:0] CMD_NONE     = 4'd0;
  localparam logic [3:0] CMD_STOP     = 4'd1;
  localparam logic [3:0] CMD_START    = 4'd2;
  localparam logic [3:0] CMD_START_LP = 4'd3;
  localparam logic [3:0] CMD_SINGLE   = 4'd4;
  localparam logic [3:0] CMD_READY    = 4'd5;
  localparam logic [3:0] CMD_READ     = 4'd6;
  localparam logic [3:0] CMD_PRESSURE = 4'd7;
  localparam logic [3:0] CMD_OFFSET   = 4'd8;
  localparam logic [3:0] CMD_DOWN     = 4'd9;
  localparam logic [3:0] CMD_WAKE     = 4'd10;
  localparam logic [3:0] CMD_SERIAL   = 4'd11;

  // sensor modes
  localparam logic [2:0] MODE_DOWN     = 3'd0;
  localparam logic [2:0] MODE_IDLE     = 3'd1;
  localparam logic [2:0] MODE_PERIODIC = 3'd2;
  localparam logic [2:0] MODE_LP       = 3'd3;
  localparam logic [2:0] MODE_SINGLE   = 3'd4;

  // configuration register indexes
  localparam logic [2:0] CFG_MIN_PA    = 3'd0;
  localparam logic [2:0] CFG_MAX_PA    = 3'd1;
  localparam logic [2:0] CFG_MAX_OFF   = 3'd2;
  localparam logic [2:0] CFG_RDY_MASK  = 3'd3;
  localparam logic [2:0] CFG_STOP_MS   = 3'd4;
  localparam logic [2:0] CFG_SINGLE_MS = 3'd5;
  localparam logic [2:0] CFG_WAKE_MS   = 3'd6;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 18;

  // configuration reset values
  localparam logic [17:0] RST_MIN_PA    = 18'd70000;
  localparam logic [17:0] RST_MAX_PA    = 18'd120000;
  localparam logic [15:0] RST_MAX_OFF   = 16'd44800;
  localparam logic [15:0] RST_RDY_MASK  = 16'd2047;
  localparam logic [15:0] RST_STOP_MS   = 16'd500;
  localparam logic [15:0] RST_SINGLE_MS = 16'd5000;
  localparam logic [15:0] RST_WAKE_MS   = 16'd30;

  // pa / 100 as (pa * PA_RECIP) >> PA_SHIFT, exact for 18-bit pa
  localparam int          PA_SHIFT   = 26;
  localparam logic [37:0] PA_RECIP   = 38'd671089;
  // temperature: 175 degC full scale in q8, offset -45 degC times 65535
  localparam logic [31:0] TEMP_SCALE = 32'd44800;
  localparam logic [32:0] TEMP_BIAS  = 33'd754963200;
  // humidity: 100 percent full scale in q8
  localparam logic [30:0] HUM_SCALE  = 31'd25600;

  // divider step count, quotient width of the offset scaling
  localparam int          DivSteps   = 16;
  localparam logic [3:0]  DIV_LAST   = 4'(DivSteps - 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CALC = 4'b0010,
    S_DIV  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture request
    logic calc;      // register products, seed divider
    logic div_step;  // one restoring divide step
    logic fin;       // write result and state
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_div;  // offset request that needs scaling
  } dp_sts_t;

  // floor(x / 65535) for any 32-bit x
  function automatic logic [16:0] div_65535(input logic [31:0] x);
    logic [16:0] r;
    logic [16:0] q;
    r = {1'b0, x[15:0]} + {1'b0, x[31:16]};
    q = {1'b0, x[31:16]};
    if (r >= 17'd65535) q = q + 17'd1;
    if (r >= 17'd131070) q = q + 17'd1;
    return q;
  endfunction

endpackage

// ===== sv/co2seq_ctrl.sv =====
// control state machine of the co2 sensor command sequencer
module co2seq_ctrl import co2seq_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t     state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = sts.need_div ? S_DIV : S_FIN;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 4'd1;
        if (cnt_r == DIV_LAST) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (slot_free) begin
          cmd.fin       = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== sv/co2seq_dp.sv =====
// datapath of the co2 sensor command sequencer: config, mode state, decode, divider
module co2seq_dp import co2seq_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  dp_cmd_t             cmd,
  output dp_sts_t             sts,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic [3:0]          in_func,
  input  logic [31:0]         in_now_ms,
  input  logic [17:0]         in_pressure_pa,
  input  logic [15:0]         in_offset_q8,
  input  logic                in_write_ack,
  input  logic                in_read_ok,
  input  logic [15:0]         in_answer_first,
  input  logic [15:0]         in_answer_second,
  input  logic [15:0]         in_answer_third,
  output logic                out_ok,
  output logic [3:0]          out_command,
  output logic [15:0]         out_command_arg,
  output logic                out_serial_query,
  output logic [2:0]          out_new_mode,
  output logic                out_data_ready,
  output logic [15:0]         out_co2_ppm,
  output logic signed [16:0]  out_temp_q8,
  output logic [14:0]         out_humidity_q8,
  output logic [47:0]         out_serial_number
);

  // configuration
  logic [17:0] min_pa_r, max_pa_r;
  logic [15:0] max_off_r, rdy_mask_r, stop_ms_r, single_ms_r, wake_ms_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_pa_r    <= RST_MIN_PA;
      max_pa_r    <= RST_MAX_PA;
      max_off_r   <= RST_MAX_OFF;
      rdy_mask_r  <= RST_RDY_MASK;
      stop_ms_r   <= RST_STOP_MS;
      single_ms_r <= RST_SINGLE_MS;
      wake_ms_r   <= RST_WAKE_MS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_PA:    min_pa_r    <= cfg_data;
        CFG_MAX_PA:    max_pa_r    <= cfg_data;
        CFG_MAX_OFF:   max_off_r   <= cfg_data[15:0];
        CFG_RDY_MASK:  rdy_mask_r  <= cfg_data[15:0];
        CFG_STOP_MS:   stop_ms_r   <= cfg_data[15:0];
        CFG_SINGLE_MS: single_ms_r <= cfg_data[15:0];
        CFG_WAKE_MS:   wake_ms_r   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // captured request
  logic [3:0]  func_r;
  logic [31:0] now_r;
  logic [17:0] pa_r;
  logic [15:0] off_r, w0_r, w1_r, w2_r;
  logic        ack_r, rok_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      now_r  <= in_now_ms;
      pa_r   <= in_pressure_pa;
      off_r  <= in_offset_q8;
      ack_r  <= in_write_ack;
      rok_r  <= in_read_ok;
      w0_r   <= in_answer_first;
      w1_r   <= in_answer_second;
      w2_r   <= in_answer_third;
    end
  end

  // sensor state
  logic [2:0]  mode_r, mode_nxt;
  logic [31:0] busy_r, busy_nxt;
  logic [31:0] busy_diff;
  logic        busy;

  assign busy_diff = busy_r - now_r;
  assign busy      = (busy_diff != 32'd0) && !busy_diff[31];

  // products and divider
  logic [37:0] prod_pa_r;
  logic [31:0] prod_t_r;
  logic [30:0] prod_h_r;
  logic [33:0] num;
  logic [16:0] divisor;
  logic [16:0] rem_r;
  logic [15:0] quo_r;
  logic [17:0] trial, diff;
  logic        ge;

  // (off * 131070 + max) / (2 * max): rounded scaling to full 16-bit range
  assign num     = {1'b0, off_r, 17'b0} - {17'b0, off_r, 1'b0} + {18'b0, max_off_r};
  assign divisor = {max_off_r, 1'b0};
  assign trial   = {rem_r, quo_r[15]};
  assign diff    = trial - {1'b0, divisor};
  assign ge      = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      prod_pa_r <= 38'(pa_r) * PA_RECIP;
      prod_t_r  <= 32'(w1_r) * TEMP_SCALE;
      prod_h_r  <= 31'(w2_r) * HUM_SCALE;
      rem_r     <= num[32:16];
      quo_r     <= num[15:0];
    end else if (cmd.div_step) begin
      rem_r <= ge ? diff[16:0] : trial[16:0];
      quo_r <= {quo_r[14:0], ge};
    end
  end

  assign sts.need_div = (func_r == FN_OFFSET) && (mode_r == MODE_IDLE) &&
                        (off_r <= max_off_r) && (max_off_r != 16'd0);

  // final decode
  logic [32:0]        t_n;
  logic               t_neg;
  logic [31:0]        t_mag;
  logic [16:0]        t_q;
  logic [16:0]        h_q;
  logic               ok, sq, rdy, serial_after;
  logic [3:0]         cmd_code;
  logic [15:0]        arg, ppm;
  logic signed [16:0] temp;
  logic [14:0]        hum;
  logic [47:0]        ser;

  assign t_n   = {1'b0, prod_t_r} - TEMP_BIAS;
  assign t_neg = t_n[32];
  assign t_mag = t_neg ? 32'(-t_n) : t_n[31:0];
  assign t_q   = div_65535(t_mag);
  assign h_q   = div_65535({1'b0, prod_h_r});

  always_comb begin
    ok           = 1'b0;
    cmd_code     = CMD_NONE;
    arg          = '0;
    sq           = 1'b0;
    rdy          = 1'b0;
    ppm          = '0;
    temp         = '0;
    hum          = '0;
    ser          = '0;
    serial_after = 1'b0;
    mode_nxt     = mode_r;
    busy_nxt     = busy_r;
    unique case (func_r) inside
      FN_BEGIN: begin
        cmd_code     = CMD_STOP;
        mode_nxt     = MODE_IDLE;
        busy_nxt     = now_r + 32'(stop_ms_r);
        serial_after = 1'b1;
      end
      FN_WAKE: begin
        if (mode_r == MODE_DOWN) begin
          cmd_code     = CMD_WAKE;
          mode_nxt     = MODE_IDLE;
          busy_nxt     = now_r + 32'(wake_ms_r);
          serial_after = 1'b1;
        end
      end
      FN_START, FN_START_LP, FN_SINGLE: begin
        if (mode_r == MODE_IDLE && !busy) begin
          if (func_r == FN_START) begin
            cmd_code = CMD_START;
          end else if (func_r == FN_START_LP) begin
            cmd_code = CMD_START_LP;
          end else begin
            cmd_code = CMD_SINGLE;
          end
          if (ack_r) begin
            ok = 1'b1;
            if (func_r == FN_START) begin
              mode_nxt = MODE_PERIODIC;
            end else if (func_r == FN_START_LP) begin
              mode_nxt = MODE_LP;
            end else begin
              mode_nxt = MODE_SINGLE;
              busy_nxt = now_r + 32'(single_ms_r);
            end
          end
        end
      end
      FN_STOP: begin
        if (mode_r != MODE_DOWN) begin
          cmd_code = CMD_STOP;
          if (ack_r) begin
            ok       = 1'b1;
            mode_nxt = MODE_IDLE;
            busy_nxt = now_r + 32'(stop_ms_r);
          end
        end
      end
      FN_READY: begin
        if (mode_r != MODE_DOWN && !busy) begin
          cmd_code = CMD_READY;
          if (ack_r && rok_r) begin
            ok  = 1'b1;
            rdy = |(w0_r & rdy_mask_r);
            if (rdy && mode_r == MODE_SINGLE) mode_nxt = MODE_IDLE;
          end
        end
      end
      FN_READ: begin
        if (mode_r != MODE_DOWN && !busy) begin
          cmd_code = CMD_READ;
          if (ack_r && rok_r) begin
            ok   = 1'b1;
            ppm  = w0_r;
            temp = t_neg ? -t_q : t_q;
            hum  = h_q[14:0];
            if (mode_r == MODE_SINGLE) mode_nxt = MODE_IDLE;
          end
        end
      end
      FN_PRESSURE: begin
        if (mode_r != MODE_DOWN && pa_r >= min_pa_r && pa_r <= max_pa_r) begin
          cmd_code = CMD_PRESSURE;
          arg      = 16'(prod_pa_r[37:PA_SHIFT]);
          ok       = ack_r;
        end
      end
      FN_OFFSET: begin
        if (mode_r == MODE_IDLE && off_r <= max_off_r) begin
          cmd_code = CMD_OFFSET;
          arg      = (max_off_r != 16'd0) ? quo_r : 16'd0;
          ok       = ack_r;
        end
      end
      FN_DOWN: begin
        if (mode_r == MODE_IDLE) begin
          cmd_code = CMD_DOWN;
          if (ack_r) begin
            ok       = 1'b1;
            mode_nxt = MODE_DOWN;
          end
        end
      end
      FN_SERIAL: begin
        if (mode_r != MODE_DOWN) begin
          cmd_code = CMD_SERIAL;
          if (ack_r && rok_r) begin
            ok  = 1'b1;
            ser = {w0_r, w1_r, w2_r};
          end
        end
      end
      default: ;
    endcase

    // begin and wake follow up with a serial query that decides success
    if (serial_after) begin
      sq = 1'b1;
      if (ack_r && rok_r) begin
        ok  = 1'b1;
        ser = {w0_r, w1_r, w2_r};
      end else begin
        mode_nxt = MODE_DOWN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_DOWN;
      busy_r <= '0;
    end else if (cmd.fin) begin
      mode_r <= mode_nxt;
      busy_r <= busy_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_ok            <= ok;
      out_command       <= cmd_code;
      out_command_arg   <= arg;
      out_serial_query  <= sq;
      out_new_mode      <= mode_nxt;
      out_data_ready    <= rdy;
      out_co2_ppm       <= ppm;
      out_temp_q8       <= temp;
      out_humidity_q8   <= hum;
      out_serial_number <= ser;
    end
  end

endmodule

// ===== sv/co2_sensor_command_sequencer_unit.sv =====
// top level of the co2 sensor command sequencer
//
// one request in, one result out. a request carries the software call
// (func), the current time and the bus outcome of that call; the result
// says whether it succeeded, which command went to the sensor, its
// argument word, the mode afterwards and any decoded measurement data.
// both channels use valid/stall; a request is taken at an edge with
// in_valid high and in_stall low, a result likewise on the out side.
// steps: a request is captured, its products are registered, and for a
// scaled temperature offset a restoring divider then forms the 16-bit
// quotient at one bit per cycle; the result register is loaded last. a new
// request is taken the cycle after the result is loaded.
// the result sits in an output register: a stalled receiver holds it and
// the next request is still taken; its result waits in the last step
// until the register frees up.
// reset (rst_n low, synchronous) puts the sensor mode to powered down,
// clears the busy time and loads the default pressure window, offset
// full scale, ready mask and busy times. config writes go through cfg_*;
// the user must issue them with no request in flight; nothing checks it.
`include "assert_macros.svh"

module co2_sensor_command_sequencer_unit import co2seq_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  // config write port
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  // request channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [3:0]          in_func,
  input  logic [31:0]         in_now_ms,
  input  logic [17:0]         in_pressure_pa,
  input  logic [15:0]         in_offset_q8,
  input  logic                in_write_ack,
  input  logic                in_read_ok,
  input  logic [15:0]         in_answer_first,
  input  logic [15:0]         in_answer_second,
  input  logic [15:0]         in_answer_third,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_ok,
  output logic [3:0]          out_command,
  output logic [15:0]         out_command_arg,
  output logic                out_serial_query,
  output logic [2:0]          out_new_mode,
  output logic                out_data_ready,
  output logic [15:0]         out_co2_ppm,
  output logic signed [16:0]  out_temp_q8,
  output logic [14:0]         out_humidity_q8,
  output logic [47:0]         out_serial_number
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;
  logic    query_cmd_ok;

  // sequencing: capture, multiply, optional divide, result write
  co2seq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (dp_sts),
    .cmd       (dp_cmd)
  );

  // mode machine, guards, decoding and output register
  co2seq_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (dp_cmd),
    .sts               (dp_sts),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_func           (in_func),
    .in_now_ms         (in_now_ms),
    .in_pressure_pa    (in_pressure_pa),
    .in_offset_q8      (in_offset_q8),
    .in_write_ack      (in_write_ack),
    .in_read_ok        (in_read_ok),
    .in_answer_first   (in_answer_first),
    .in_answer_second  (in_answer_second),
    .in_answer_third   (in_answer_third),
    .out_ok            (out_ok),
    .out_command       (out_command),
    .out_command_arg   (out_command_arg),
    .out_serial_query  (out_serial_query),
    .out_new_mode      (out_new_mode),
    .out_data_ready    (out_data_ready),
    .out_co2_ppm       (out_co2_ppm),
    .out_temp_q8       (out_temp_q8),
    .out_humidity_q8   (out_humidity_q8),
    .out_serial_number (out_serial_number)
  );

  // commands that may carry a serial query: stop from begin, or wake
  assign query_cmd_ok = (out_command == CMD_STOP) || (out_command == CMD_WAKE);

  // a taken request blocks the next one in the cycle after it
  `ASSERT_IMPL(a_stall_after_accept, clk, rst_n, (in_valid && !in_stall) |=> in_stall)
  // success always comes with an issued command
  `ASSERT_NEVER(a_ok_has_cmd, clk, rst_n, out_valid && out_ok && out_command == CMD_NONE)
  // serial query only follows begin (stop) or wake
  `ASSERT_NEVER(a_query_cmd, clk, rst_n, out_valid && out_serial_query && !query_cmd_ok)

endmodule

// ===== sim/tb_top.sv =====
// self-checking testbench of the co2 sensor command sequencer unit
`timescale 1ns / 100ps

module tb_top import co2seq_pkg::*; ();

  // func codes 12 to 15 carry no request and are ignored by the block
  localparam logic [3:0] FN_FIRST_UNUSED = 4'd12;
  localparam logic [3:0] FN_LAST_UNUSED  = 4'd15;
  localparam int STUCK_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 30;
  localparam int LONG_HOLD    = 150;

  typedef struct packed {
    logic [3:0]  func;
    logic [31:0] now_ms;
    logic [17:0] pressure_pa;
    logic [15:0] offset_q8;
    logic        write_ack;
    logic        read_ok;
    logic [15:0] word_a;
    logic [15:0] word_b;
    logic [15:0] word_c;
  } sensor_call_t;

  typedef struct packed {
    logic        ok;
    logic [3:0]  command;
    logic [15:0] command_arg;
    logic        serial_query;
    logic [2:0]  new_mode;
    logic        data_ready;
    logic [15:0] co2_ppm;
    logic [16:0] temp_q8;
    logic [14:0] humidity_q8;
    logic [47:0] serial_number;
  } sensor_reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [3:0]  in_func = '0;
  logic [31:0] in_now_ms = '0;
  logic [17:0] in_pressure_pa = '0;
  logic [15:0] in_offset_q8 = '0;
  logic        in_write_ack = 1'b0;
  logic        in_read_ok = 1'b0;
  logic [15:0] in_answer_first = '0;
  logic [15:0] in_answer_second = '0;
  logic [15:0] in_answer_third = '0;

  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_ok;
  logic [3:0]         out_command;
  logic [15:0]        out_command_arg;
  logic               out_serial_query;
  logic [2:0]         out_new_mode;
  logic               out_data_ready;
  logic [15:0]        out_co2_ppm;
  logic signed [16:0] out_temp_q8;
  logic [14:0]        out_humidity_q8;
  logic [47:0]        out_serial_number;

  co2_sensor_command_sequencer_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_now_ms        (in_now_ms),
    .in_pressure_pa   (in_pressure_pa),
    .in_offset_q8     (in_offset_q8),
    .in_write_ack     (in_write_ack),
    .in_read_ok       (in_read_ok),
    .in_answer_first  (in_answer_first),
    .in_answer_second (in_answer_second),
    .in_answer_third  (in_answer_third),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_ok           (out_ok),
    .out_command      (out_command),
    .out_command_arg  (out_command_arg),
    .out_serial_query (out_serial_query),
    .out_new_mode     (out_new_mode),
    .out_data_ready   (out_data_ready),
    .out_co2_ppm      (out_co2_ppm),
    .out_temp_q8      (out_temp_q8),
    .out_humidity_q8  (out_humidity_q8),
    .out_serial_number(out_serial_number)
  );

  always #2 clk = ~clk;

  // shadow copy of the register file, kept in step with every cfg write
  logic [17:0] win_lo_pa      = RST_MIN_PA;
  logic [17:0] win_hi_pa      = RST_MAX_PA;
  logic [15:0] off_full_q8    = RST_MAX_OFF;
  logic [15:0] rdy_bits       = RST_RDY_MASK;
  logic [15:0] stop_hold_ms   = RST_STOP_MS;
  logic [15:0] single_hold_ms = RST_SINGLE_MS;
  logic [15:0] wake_hold_ms   = RST_WAKE_MS;

  // shadow sensor state: mode and the time the sensor stays busy until
  logic [2:0]  sim_mode       = MODE_DOWN;
  logic [31:0] sim_busy_until = '0;

  sensor_call_t  call_queue[$];        // requests waiting to be driven
  sensor_reply_t predicted_replies[$]; // replies owed by the block, oldest first
  sensor_call_t  offered;              // request currently on the input port

  logic [31:0] wall_ms = '0;           // time base handed to the block
  bit          quiet = 1'b0;           // no idling on either side
  int          tx_gap = 0;
  int          rx_hold = 0;
  int          long_hold_order = 0;
  int          long_hold_done = 0;
  int          stuck_cycles = 0;
  int          n_fail = 0;
  int          n_requests = 0;
  int          n_replies = 0;
  int          n_done_ok = 0;
  int          n_refused = 0;
  int          n_settings = 1;

  // one request applied to the shadow sensor; returns the reply it owes
  function automatic sensor_reply_t run_sensor_call(sensor_call_t c);
    sensor_reply_t r;
    logic [31:0]   left;
    logic          busy;
    logic          serial_next;
    longint        deg;
    logic [63:0]   num;
    r = '0;
    serial_next = 1'b0;
    // wrap-safe: busy while busy_until lies strictly ahead of now
    left = sim_busy_until - c.now_ms;
    busy = (left != 32'd0) && !left[31];
    case (c.func)
      FN_BEGIN: begin
        // stop goes out unchecked, then the serial query decides
        r.command = CMD_STOP;
        sim_mode = MODE_IDLE;
        sim_busy_until = c.now_ms + 32'(stop_hold_ms);
        serial_next = 1'b1;
      end
      FN_WAKE: begin
        if (sim_mode == MODE_DOWN) begin
          r.command = CMD_WAKE;
          sim_mode = MODE_IDLE;
          sim_busy_until = c.now_ms + 32'(wake_hold_ms);
          serial_next = 1'b1;
        end
      end
      FN_START, FN_START_LP, FN_SINGLE: begin
        if (sim_mode == MODE_IDLE && !busy) begin
          r.command = (c.func == FN_START) ? CMD_START :
                      (c.func == FN_START_LP) ? CMD_START_LP : CMD_SINGLE;
          if (c.write_ack) begin
            r.ok = 1'b1;
            if (c.func == FN_START) begin
              sim_mode = MODE_PERIODIC;
            end else if (c.func == FN_START_LP) begin
              sim_mode = MODE_LP;
            end else begin
              sim_mode = MODE_SINGLE;
              sim_busy_until = c.now_ms + 32'(single_hold_ms);
            end
          end
        end
      end
      FN_STOP: begin
        if (sim_mode != MODE_DOWN) begin
          r.command = CMD_STOP;
          if (c.write_ack) begin
            r.ok = 1'b1;
            sim_mode = MODE_IDLE;
            sim_busy_until = c.now_ms + 32'(stop_hold_ms);
          end
        end
      end
      FN_READY: begin
        if (sim_mode != MODE_DOWN && !busy) begin
          r.command = CMD_READY;
          if (c.write_ack && c.read_ok) begin
            r.ok = 1'b1;
            r.data_ready = (c.word_a & rdy_bits) != 16'd0;
            if (r.data_ready && sim_mode == MODE_SINGLE) sim_mode = MODE_IDLE;
          end
        end
      end
      FN_READ: begin
        if (sim_mode != MODE_DOWN && !busy) begin
          r.command = CMD_READ;
          if (c.write_ack && c.read_ok) begin
            r.ok = 1'b1;
            r.co2_ppm = c.word_a;
            // -45 + 175 * raw / 65535 in q8, truncated toward zero
            deg = longint'(c.word_b) * 44800 - longint'(11520) * 65535;
            deg = deg / 65535;
            r.temp_q8 = deg[16:0];
            num = 64'(c.word_c) * 64'd25600 / 64'd65535;
            r.humidity_q8 = num[14:0];
            if (sim_mode == MODE_SINGLE) sim_mode = MODE_IDLE;
          end
        end
      end
      FN_PRESSURE: begin
        if (sim_mode != MODE_DOWN && c.pressure_pa >= win_lo_pa &&
            c.pressure_pa <= win_hi_pa) begin
          r.command = CMD_PRESSURE;
          num = 64'(c.pressure_pa) / 64'd100;
          r.command_arg = num[15:0];
          r.ok = c.write_ack;
        end
      end
      FN_OFFSET: begin
        if (sim_mode == MODE_IDLE && c.offset_q8 <= off_full_q8) begin
          r.command = CMD_OFFSET;
          // offset scaled to 16-bit full scale, rounded half up
          if (off_full_q8 != 16'd0) begin
            num = (64'(c.offset_q8) * 64'd131070 + 64'(off_full_q8)) /
                  (64'(off_full_q8) * 64'd2);
            r.command_arg = num[15:0];
          end
          r.ok = c.write_ack;
        end
      end
      FN_DOWN: begin
        if (sim_mode == MODE_IDLE) begin
          r.command = CMD_DOWN;
          if (c.write_ack) begin
            r.ok = 1'b1;
            sim_mode = MODE_DOWN;
          end
        end
      end
      FN_SERIAL: begin
        if (sim_mode != MODE_DOWN) begin
          r.command = CMD_SERIAL;
          if (c.write_ack && c.read_ok) begin
            r.ok = 1'b1;
            r.serial_number = {c.word_a, c.word_b, c.word_c};
          end
        end
      end
      default: ;
    endcase
    // begin and wake: a failed serial query powers the sensor back down
    if (serial_next) begin
      r.serial_query = 1'b1;
      if (c.write_ack && c.read_ok) begin
        r.ok = 1'b1;
        r.serial_number = {c.word_a, c.word_b, c.word_c};
      end else begin
        sim_mode = MODE_DOWN;
      end
    end
    r.new_mode = sim_mode;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // request driver: presents queued requests, random gaps between them
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predicted_replies.push_back(run_sensor_call(offered));
        n_requests++;
      end
      // payload only moves once the current request is taken
      if (!in_valid || !in_stall) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (call_queue.size() > 0) begin
          offered = call_queue.pop_front();
          in_valid         <= 1'b1;
          in_func          <= offered.func;
          in_now_ms        <= offered.now_ms;
          in_pressure_pa   <= offered.pressure_pa;
          in_offset_q8     <= offered.offset_q8;
          in_write_ack     <= offered.write_ack;
          in_read_ok       <= offered.read_ok;
          in_answer_first  <= offered.word_a;
          in_answer_second <= offered.word_b;
          in_answer_third  <= offered.word_c;
          if (!quiet && $urandom_range(0, 5) == 0) tx_gap = $urandom_range(1, 19);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_fail++;
    end
  endtask

  // ---------------------------------------------------------------------
  // reply monitor: checks each taken reply, drives random stall bursts
  // ---------------------------------------------------------------------
  sensor_reply_t got_reply, want_reply;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got_reply.ok            = out_ok;
        got_reply.command       = out_command;
        got_reply.command_arg   = out_command_arg;
        got_reply.serial_query  = out_serial_query;
        got_reply.new_mode      = out_new_mode;
        got_reply.data_ready    = out_data_ready;
        got_reply.co2_ppm       = out_co2_ppm;
        got_reply.temp_q8       = out_temp_q8;
        got_reply.humidity_q8   = out_humidity_q8;
        got_reply.serial_number = out_serial_number;
        n_replies++;
        if (predicted_replies.size() == 0) begin
          $error("reply with no request outstanding: command %0d", out_command);
          n_fail++;
        end else begin
          want_reply = predicted_replies.pop_front();
          check_field("ok", want_reply.ok, got_reply.ok);
          check_field("command", want_reply.command, got_reply.command);
          check_field("command_arg", want_reply.command_arg, got_reply.command_arg);
          check_field("serial_query", want_reply.serial_query, got_reply.serial_query);
          check_field("new_mode", want_reply.new_mode, got_reply.new_mode);
          check_field("data_ready", want_reply.data_ready, got_reply.data_ready);
          check_field("co2_ppm", want_reply.co2_ppm, got_reply.co2_ppm);
          check_field("temp_q8", want_reply.temp_q8, got_reply.temp_q8);
          check_field("humidity_q8", want_reply.humidity_q8, got_reply.humidity_q8);
          check_field("serial_number", want_reply.serial_number,
                      got_reply.serial_number);
          if (want_reply.ok) n_done_ok++;
          if (want_reply.command == CMD_NONE) n_refused++;
        end
      end
      // a long hold asked for by the sequence fills the block up
      if (long_hold_done != long_hold_order) begin
        long_hold_done = long_hold_order;
        rx_hold = LONG_HOLD;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        rx_hold = $urandom_range(1, 19) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog: too long without any request or reply moving
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cycles = 0;
      else stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("co2_sensor_command_sequencer_unit test failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // sequence helpers
  // ---------------------------------------------------------------------
  task automatic push_call(logic [3:0] fn, logic [31:0] now, logic ack, logic rok,
                           logic [17:0] pa, logic [15:0] off,
                           logic [15:0] wa, logic [15:0] wb, logic [15:0] wc);
    sensor_call_t c;
    c.func = fn;
    c.now_ms = now;
    c.write_ack = ack;
    c.read_ok = rok;
    c.pressure_pa = pa;
    c.offset_q8 = off;
    c.word_a = wa;
    c.word_b = wb;
    c.word_c = wc;
    call_queue.push_back(c);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [17:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_MIN_PA:    win_lo_pa = val;
      CFG_MAX_PA:    win_hi_pa = val;
      CFG_MAX_OFF:   off_full_q8 = val[15:0];
      CFG_RDY_MASK:  rdy_bits = val[15:0];
      CFG_STOP_MS:   stop_hold_ms = val[15:0];
      CFG_SINGLE_MS: single_hold_ms = val[15:0];
      CFG_WAKE_MS:   wake_hold_ms = val[15:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(logic [17:0] lo, logic [17:0] hi, logic [15:0] full,
                               logic [15:0] mask, logic [15:0] stop_ms,
                               logic [15:0] single_ms, logic [15:0] wake_ms);
    write_reg(CFG_MIN_PA, lo);
    write_reg(CFG_MAX_PA, hi);
    write_reg(CFG_MAX_OFF, 18'(full));
    write_reg(CFG_RDY_MASK, 18'(mask));
    write_reg(CFG_STOP_MS, 18'(stop_ms));
    write_reg(CFG_SINGLE_MS, 18'(single_ms));
    write_reg(CFG_WAKE_MS, 18'(wake_ms));
    @(posedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // sender pause: everything sent and every reply back, then settle;
  // checked at the falling edge so the driver's last update is visible
  task automatic drain();
    while (call_queue.size() > 0 || in_valid || predicted_replies.size() > 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_word();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 16'h0000;
    if (pick == 1) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  // weighted mix of requests, moving time so busy windows open and close
  logic [3:0] mix_func [12] = '{FN_BEGIN, FN_START, FN_START_LP, FN_STOP, FN_SINGLE,
                                FN_READY, FN_READ, FN_PRESSURE, FN_OFFSET, FN_DOWN,
                                FN_WAKE, FN_SERIAL};
  int mix_cut [12] = '{5, 15, 22, 32, 42, 56, 70, 78, 86, 90, 95, 99};

  task automatic queue_random(int count);
    sensor_call_t c;
    int pick;
    int k;
    int i;
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      c.func = 4'($urandom_range(FN_FIRST_UNUSED, FN_LAST_UNUSED));
      for (i = 11; i >= 0; i--)
        if (pick < mix_cut[i]) c.func = mix_func[i];
      pick = $urandom_range(0, 99);
      if (pick < 30) wall_ms = wall_ms + $urandom_range(0, 40);
      else if (pick < 80) wall_ms = wall_ms + $urandom_range(0, 6000);
      else if (pick < 96) wall_ms = wall_ms + $urandom_range(5000, 70000);
      else if (pick < 98) wall_ms = $urandom;
      else wall_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000); // about to wrap
      c.now_ms = wall_ms;
      c.write_ack = $urandom_range(0, 9) != 0;
      c.read_ok = $urandom_range(0, 9) != 0;
      if (win_lo_pa <= win_hi_pa && $urandom_range(0, 99) < 65)
        c.pressure_pa = 18'($urandom_range(win_lo_pa, win_hi_pa));
      else
        c.pressure_pa = 18'($urandom);
      if ($urandom_range(0, 9) < 7) c.offset_q8 = 16'($urandom_range(0, off_full_q8));
      else c.offset_q8 = 16'($urandom);
      c.word_a = rand_word();
      c.word_b = rand_word();
      c.word_c = rand_word();
      call_queue.push_back(c);
    end
  endtask

  // ---------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part under reset settings
    push_call(FN_READY, 32'd900, 1, 1, 18'd0, 16'd0, 16'hFFFF, 16'd0, 16'd0);     // refused, down
    push_call(FN_WAKE, 32'd950, 0, 1, 18'd0, 16'd0, 16'h1234, 16'd1, 16'd2);      // query fails
    push_call(FN_BEGIN, 32'd1000, 1, 1, 18'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_call(FN_START, 32'd1499, 1, 1, 18'd0, 16'd0, 16'd0, 16'd0, 16'd0);       // still busy
    push_call(FN_WAKE, 32'd1499, 1, 1, 18'd0, 16'd0, 16'd0, 16'd0, 16'd0);        // not down
    push_call(FN_PRESSURE, 32'd1499, 1, 1, 18'd69999, 16'd0, 16'd0, 16'd0, 16'd0);
    push_call(FN_PRESSURE, 32'd1499, 1, 1, 18'd70000, 16'd0, 16'd0, 16'd0, 16'd0);
    push_call(FN_PRESSURE, 32'd1499, 0, 1, 18'd120000, 16'd0, 16'd0, 16'd0, 16'd0);
    push_call(FN_PRESSURE, 32'd1499, 1, 1, 18'd120001, 16'd0, 16'd0, 16'd0, 16'd0);
    push_call(FN_OFFSET, 32'd1499, 1, 1, 18'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    push_call(FN_OFFSET, 32'd1499, 1, 1, 18'd0, 16'd44800, 16'd0, 16'd0, 16'd0);
    push_call(FN_OFFSET, 32'd1499, 1, 1, 18'd0, 16'd44801, 16'd0, 16'd0, 16'd0);
    push_call(FN_SINGLE, 32'd1500, 1, 1, 18'd0, 16'd0, 16'd0, 16'd0, 16'd0);      // busy ends
    push_call(FN_READ, 32'd6499, 1, 1, 18'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    push_call(FN_READY, 32'd6500, 1, 1, 18'd0, 16'd0, 16'd0, 16'd0, 16'd0);       // nothing yet
    push_call(FN_READ, 32'd6500, 1, 1, 18'd0, 16'd0, 16'd0, 16'd0, 16'd0);        // coldest
    push_call(FN_START, 32'd6500, 0, 1, 18'd0, 16'd0, 16'd0, 16'd0, 16'd0);       // no ack
    push_call(FN_START_LP, 32'd6500, 1, 1, 18'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    push_call(FN_READ, 32'd6501, 1, 1, 18'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_call(FN_SERIAL, 32'd6501, 1, 0, 18'd0, 16'd0, 16'h5555, 16'hAAAA, 16'h0F0F);
    push_call(FN_SERIAL, 32'd6501, 1, 1, 18'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    push_call(FN_STOP, 32'd6502, 1, 1, 18'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    push_call(FN_DOWN, 32'd6502, 1, 1, 18'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    push_call(FN_FIRST_UNUSED, 32'd6600, 1, 1, 18'h3FFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
    push_call(FN_LAST_UNUSED, 32'd6600, 1, 1, 18'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    push_call(FN_WAKE, 32'd7000, 1, 1, 18'd0, 16'd0, 16'hBEEF, 16'h0001, 16'h8000);
    wall_ms = 32'd7000;
    queue_random(250);
    drain();

    // widest window, largest offset scale, every status bit, zero busy times;
    // the receiver holds off for a long stretch while requests keep coming
    load_settings(18'd0, 18'h3FFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd0);
    queue_random(250);
    long_hold_order++;
    drain();

    // empty window, tiny offset scale, no ready bits, longest busy times
    load_settings(18'h3FFFF, 18'd0, 16'd1, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_random(200);
    drain();

    // zero offset scale: only offset 0 goes through, with argument 0
    load_settings(18'd80000, 18'd100000, 16'd0, 16'd1, 16'd100, 16'd200, 16'd10);
    queue_random(200);
    drain();

    load_settings(18'($urandom_range(50000, 100000)), 18'($urandom_range(100000, 180000)),
                  16'($urandom_range(1, 65535)), 16'($urandom),
                  16'($urandom_range(0, 8000)), 16'($urandom_range(0, 8000)),
                  16'($urandom_range(0, 8000)));
    queue_random(300);
    drain();

    // back to the reset values, no idling on either side
    load_settings(RST_MIN_PA, RST_MAX_PA, RST_MAX_OFF, RST_RDY_MASK, RST_STOP_MS,
                  RST_SINGLE_MS, RST_WAKE_MS);
    quiet = 1'b1;
    queue_random(250);
    drain();

    $display("ran %0d requests under %0d register settings, %0d replies checked",
             n_requests, n_settings, n_replies);
    $display("%0d requests succeeded, %0d were refused by mode or busy guards",
             n_done_ok, n_refused);
    if (n_fail == 0 && predicted_replies.size() == 0) begin
      $display("co2_sensor_command_sequencer_unit test passed");
    end else begin
      $display("co2_sensor_command_sequencer_unit test failed");
    end
    $finish;
  end

endmodule
